[design/gece_pixel_line_encoder_defines.svh]
// ----------------------------------------------------------------------------
// gece_pixel_line_encoder_defines: assertion macros
// Shared property wrappers for the pixel line encoder checks.
// ----------------------------------------------------------------------------
`ifndef GECE_PIXEL_LINE_ENCODER_DEFINES_SVH
`define GECE_PIXEL_LINE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg
// Types and constants shared by the pixel line encoder modules.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int PACKET_BITS = 26;
  localparam int BIT_IDX_W   = (PACKET_BITS > 1) ? $clog2(PACKET_BITS) : 1;
  localparam int TICK_W      = 16;
  localparam int PHASE_W     = 3;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_START = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LOW   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;

  localparam logic [TICK_W-1:0] SHORT_RST = 16'd800;
  localparam logic [TICK_W-1:0] LONG_RST  = 16'd1600;
  localparam logic [TICK_W-1:0] GAP_RST   = 16'd2800;
  localparam logic [TICK_W-1:0] GAP_SAT   = '1;

  typedef struct packed {
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] gap_ticks;
  } gpe_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [TICK_W-1:0]      tick_count;
    logic [BIT_IDX_W-1:0]   bit_index;
    logic [PACKET_BITS-1:0] shift_word;
    logic [TICK_W-1:0]      gap_count;
  } gpe_state_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } gpe_result_t;

endpackage

[design/gpe_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_cfg
// APB register file for the interval and gap timing registers.
// ----------------------------------------------------------------------------
module gpe_cfg
  import gpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output gpe_cfg_t    cfg_o
);

  gpe_cfg_t cfg_r;
  gpe_cfg_t cfg_nxt;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_SHORT: cfg_nxt.short_ticks = cfg_pwdata[TICK_W-1:0];
        REG_LONG:  cfg_nxt.long_ticks  = cfg_pwdata[TICK_W-1:0];
        REG_GAP:   cfg_nxt.gap_ticks   = cfg_pwdata[TICK_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks <= SHORT_RST;
      cfg_r.long_ticks  <= LONG_RST;
      cfg_r.gap_ticks   <= GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SHORT: cfg_prdata = {16'd0, cfg_r.short_ticks};
      REG_LONG:  cfg_prdata = {16'd0, cfg_r.long_ticks};
      REG_GAP:   cfg_prdata = {16'd0, cfg_r.gap_ticks};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

[design/gpe_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_step
// One tick of the waveform sequencer: next state and line result.
// ----------------------------------------------------------------------------
module gpe_step
  import gpe_pkg::*;
(
  input  gpe_cfg_t               cfg_i,
  input  gpe_state_t             st_i,
  input  logic                   op_i,
  input  logic [PACKET_BITS-1:0] packet_i,
  output gpe_state_t             st_o,
  output gpe_result_t            res_o
);

  logic [PHASE_W-1:0]  ph;
  logic [TICK_W-1:0]   len;
  logic [TICK_W:0]     tick_inc;
  logic                done;
  logic                cur_bit;
  logic                rej;
  logic                level;
  gpe_state_t          nx;

  always_comb begin
    nx      = st_i;
    rej     = 1'b0;
    level   = 1'b0;
    len     = cfg_i.short_ticks;
    ph      = (st_i.phase > PH_HIGH) ? PH_IDLE : st_i.phase;

    if (op_i) begin
      if (ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        nx.shift_word = packet_i;
        ph            = PH_WAIT;
        nx.tick_count = '0;
      end
    end

    if (ph == PH_WAIT && st_i.gap_count >= cfg_i.gap_ticks) begin
      ph            = PH_START;
      nx.tick_count = '0;
    end

    cur_bit = nx.shift_word[nx.bit_index];
    case (ph)
      PH_LOW:  len = cur_bit ? cfg_i.long_ticks : cfg_i.short_ticks;
      PH_HIGH: len = cur_bit ? cfg_i.short_ticks : cfg_i.long_ticks;
      default: len = cfg_i.short_ticks;
    endcase

    // interval ends once the incremented count reaches the length
    tick_inc = {1'b0, nx.tick_count} + 17'd1;
    done     = tick_inc >= {1'b0, len};

    case (ph)
      PH_START, PH_LOW, PH_HIGH: begin
        level         = (ph != PH_LOW);
        nx.tick_count = done ? '0 : tick_inc[TICK_W-1:0];
        if (done) begin
          case (ph)
            PH_START: begin
              ph           = PH_LOW;
              nx.bit_index = BIT_IDX_W'(PACKET_BITS - 1);
            end
            PH_LOW: ph = PH_HIGH;
            default: begin
              if (nx.bit_index == '0) begin
                ph           = PH_IDLE;
                nx.gap_count = '0;
              end else begin
                nx.bit_index = nx.bit_index - 1'b1;
                ph           = PH_LOW;
              end
            end
          endcase
        end
      end
      default: begin
        // idle or waiting: gap counter runs and saturates
        if (st_i.gap_count != GAP_SAT) begin
          nx.gap_count = st_i.gap_count + 1'b1;
        end
      end
    endcase

    nx.phase = ph;
  end

  assign st_o             = nx;
  assign res_o.line_level = level;
  assign res_o.busy_res   = (nx.phase != PH_IDLE);
  assign res_o.rejected   = rej;

endmodule

[design/gece_pixel_line_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gece_pixel_line_encoder
// Pixel packet line encoder: one input transaction is one timer tick.
// ----------------------------------------------------------------------------
// Channel | Dir | Transaction content
// in_     | in  | tuser[0] op, tdata[25:0] packet
// out_    | out | tdata[0] line_level, [1] busy_res, [2] rejected
// cfg_    | in  | APB: 0x0 short_ticks, 0x4 long_ticks, 0x8 gap_ticks
//
// One transaction per cycle sustained while out_tready stays high; each item
// is held in the input register, then the step logic writes the result register.
// The sequencer state updates only when an item moves into the result register.
// Synchronous active-low reset clears state; the gap counts as already elapsed.
// Stalling out_tready holds the result; the input register keeps taking items
// while the result is taken in the same cycle.
// ----------------------------------------------------------------------------
`include "gece_pixel_line_encoder_defines.svh"

module gece_pixel_line_encoder
  import gpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [25:0] packet, rest zero
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] line_level, [1] busy_res, [2] rejected
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  gpe_cfg_t               cfg;
  gpe_state_t             st_r;
  gpe_state_t             st_nxt;
  gpe_result_t            res;
  gpe_result_t            res_r;
  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [PACKET_BITS-1:0] s1_pkt_r;
  logic                   out_valid_r;
  logic                   adv;
  logic                   in_acc;

  gpe_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  gpe_step u_step (
    .cfg_i    (cfg),
    .st_i     (st_r),
    .op_i     (s1_op_r),
    .packet_i (s1_pkt_r),
    .st_o     (st_nxt),
    .res_o    (res)
  );

  // item in the input register moves on when the result slot frees up
  assign adv       = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_tuser[0];
      s1_pkt_r <= in_tdata[PACKET_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_IDLE;
      st_r.tick_count <= '0;
      st_r.bit_index  <= '0;
      st_r.shift_word <= '0;
      st_r.gap_count  <= GAP_SAT;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.rejected, res_r.busy_res, res_r.line_level};

  `GPE_ASSERT_NOW(a_phase_legal, clk, rst_n, 1'b1, st_r.phase <= PH_HIGH, "phase code out of range")
  `GPE_ASSERT_NOW(a_bit_idx_range, clk, rst_n, 1'b1, st_r.bit_index < BIT_IDX_W'(PACKET_BITS), "bit index out of range")
  `GPE_ASSERT_NOW(a_ready_when_free, clk, rst_n, !out_valid_r, in_tready, "input stalled with free result slot")
  `GPE_ASSERT_NEXT(a_state_hold, clk, rst_n, !adv, $stable(st_r), "state changed without an item")

endmodule
